FILE: rtl/ffsa_pkg.sv
package ffsa_pkg;

    localparam int unsigned LEN_W   = 21;
    localparam int unsigned START_W = 20;
    localparam int unsigned ID_W    = 32;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOFIT    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [LEN_W-1:0] alloc_size;
        logic [ID_W-1:0]  free_id;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [ID_W-1:0]    granted_id;
        logic [START_W-1:0] granted_start;
    } t_resp;

    // one table entry as stored in the segment RAM
    typedef struct packed {
        logic             used;
        logic [LEN_W-1:0] start;
        logic [LEN_W-1:0] length;
        logic [ID_W-1:0]  owner;
    } t_seg;

    localparam int unsigned SEG_W = 1 + LEN_W + LEN_W + ID_W;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SPLIT_WR,
        S_MERGE_RD,
        S_MERGE_CHK,
        S_MERGE_WR,
        S_DONE
    } t_state;

    // steps of a release: left neighbour, right neighbour, compaction
    typedef enum logic [1:0] {
        M_LEFT,
        M_RIGHT,
        M_MOVE
    } t_mphase;

endpackage

FILE: rtl/ffsa_ram.sv
module ffsa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/first_fit_segment_allocator.sv
// First-fit segment allocator. One request is taken at a rising edge where start
// is high and busy is low; exactly one result follows, shown for one cycle on
// o_done, unless the size register is written meanwhile, and the receiver cannot
// stall it. The segment table sits in one RAM with a registered read, so every
// table step takes a read state and then a check or write state. Busy stays high
// after acceptance while the table is searched; an allocation that splits a segment
// also shifts the entries above it up (search and upward shift together touch every
// entry), and a release checks both neighbours and moves the entries above down.
// o_done is high in the same cycle in which busy falls. After reset and after each
// write of the size register the block clears all MAX_SEGMENTS table entries and
// holds busy meanwhile. A free request merges only with its two neighbours; free
// segments never touch one another, so this gives the same table as a full
// coalescing pass.
module first_fit_segment_allocator
    import ffsa_pkg::*;
#(
    parameter int unsigned MAX_SEGMENTS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_req             i_req,
    output logic             o_done,
    output t_resp            o_resp,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_data
);

    localparam int unsigned AW = $clog2(MAX_SEGMENTS);
    localparam int unsigned CW = AW + 1;
    localparam logic [LEN_W-1:0] MEM_LIMIT = LEN_W'(1) << START_W;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);

    t_state r_state, n_state;
    t_mphase          r_phase, n_phase;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_ptr, n_ptr;
    logic [CW-1:0]    r_gap, n_gap;
    logic [LEN_W-1:0] r_msize, n_msize;
    logic [ID_W-1:0]  r_idc, n_idc;
    t_req             r_req, n_req;
    t_seg             r_hit, n_hit;
    t_resp            r_resp, n_resp;
    logic             r_done, n_done;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    t_seg             wdata, rdata;
    logic [SEG_W-1:0] rraw;
    logic [LEN_W-1:0] cfg_val;
    logic [LEN_W-1:0] rest;
    logic             accept;

    ffsa_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rraw)
    );
    assign rdata = t_seg'(rraw);

    assign busy   = (r_state != S_IDLE) || i_cfg_we;
    assign accept = start && !busy;
    assign o_done = r_done;
    assign o_resp = r_resp;

    always_comb begin
        cfg_val = i_cfg_data;
        if (cfg_val == '0) cfg_val = LEN_W'(1);
        if (cfg_val > MEM_LIMIT) cfg_val = MEM_LIMIT;
    end

    assign rest = rdata.length - r_req.alloc_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_phase <= M_LEFT;
            r_cnt   <= CW'(1);
            r_idx   <= '0;
            r_gap   <= '0;
            r_msize <= MEM_LIMIT;
            r_idc   <= ID_W'(1);
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_gap   <= n_gap;
            r_msize <= n_msize;
            r_idc   <= n_idc;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_req  <= n_req;
        r_hit  <= n_hit;
        r_resp <= n_resp;
    end

    // next state
    always_comb begin
        n_state = r_state;
        if (i_cfg_we) begin
            n_state = S_CLEAR;
        end else begin
            case (r_state)
                S_CLEAR:    if (r_idx == CW'(MAX_SEGMENTS - 1)) n_state = S_IDLE;
                S_IDLE:     if (start) n_state = S_SCAN_RD;
                S_SCAN_RD:  n_state = (r_idx >= r_cnt) ? S_DONE : S_SCAN_CHK;
                S_SCAN_CHK: begin
                    if (r_req.req_type == REQ_ALLOC) begin
                        if (!rdata.used && rdata.length >= r_req.alloc_size) begin
                            if (rest != '0 && r_cnt < CNT_MAX) n_state = S_SHIFT_RD;
                            else n_state = S_DONE;
                        end else begin
                            n_state = S_SCAN_RD;
                        end
                    end else begin
                        if (rdata.used && rdata.owner == r_req.free_id)
                            n_state = S_MERGE_RD;
                        else
                            n_state = S_SCAN_RD;
                    end
                end
                S_SHIFT_RD: n_state = (r_ptr == r_idx + CW'(1)) ? S_SPLIT_WR : S_SHIFT_WR;
                S_SHIFT_WR: n_state = S_SHIFT_RD;
                S_SPLIT_WR: n_state = S_DONE;
                S_MERGE_RD:
                    n_state = (r_phase != M_LEFT && r_ptr >= r_cnt) ? S_MERGE_WR
                                                                    : S_MERGE_CHK;
                S_MERGE_CHK:
                    n_state = (r_phase == M_RIGHT && rdata.used && r_gap == '0)
                              ? S_MERGE_WR : S_MERGE_RD;
                S_MERGE_WR: n_state = S_DONE;
                S_DONE:     n_state = S_IDLE;
                default:    n_state = S_IDLE;
            endcase
        end
    end

    // datapath and outputs
    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_ptr    = r_ptr;
        n_gap    = r_gap;
        n_msize  = r_msize;
        n_idc    = r_idc;
        n_req    = r_req;
        n_hit    = r_hit;
        n_resp   = r_resp;
        n_done   = 1'b0;
        we       = 1'b0;
        waddr    = r_idx[AW-1:0];
        wdata    = '0;
        raddr    = r_idx[AW-1:0];
        if (i_cfg_we) begin
            n_msize = cfg_val;
            n_idx   = '0;
            n_cnt   = CW'(1);
        end else begin
            case (r_state)
                S_CLEAR: begin
                    we           = 1'b1;
                    wdata.length = (r_idx == '0) ? r_msize : '0;
                    n_idx        = r_idx + CW'(1);
                    if (r_idx == CW'(MAX_SEGMENTS - 1)) n_idx = '0;
                end
                S_IDLE: begin
                    if (start) begin
                        n_req  = i_req;
                        n_idx  = '0;
                        n_resp = '{status: (i_req.req_type == REQ_ALLOC) ? ST_NOFIT
                                                                      : ST_NOTFOUND,
                                   granted_id: '0, granted_start: '0};
                    end
                end
                S_SCAN_RD: raddr = r_idx[AW-1:0];
                S_SCAN_CHK: begin
                    n_idx = r_idx + CW'(1);
                    if (r_req.req_type == REQ_ALLOC) begin
                        if (!rdata.used && rdata.length >= r_req.alloc_size) begin
                            n_idx = r_idx;
                            if (rest != '0 && r_cnt >= CNT_MAX) begin
                                n_resp.status = ST_FULL;
                            end else begin
                                we           = 1'b1;
                                wdata.used   = 1'b1;
                                wdata.start  = rdata.start;
                                wdata.length = r_req.alloc_size;
                                wdata.owner  = r_idc;
                                n_resp = '{status: ST_OK, granted_id: r_idc,
                                           granted_start: rdata.start[START_W-1:0]};
                                n_idc  = (r_idc == '1) ? ID_W'(1) : r_idc + ID_W'(1);
                                n_hit.used   = 1'b0;
                                n_hit.start  = rdata.start + r_req.alloc_size;
                                n_hit.length = rest;
                                n_hit.owner  = '0;
                                n_ptr = r_cnt;
                            end
                        end
                    end else if (rdata.used && rdata.owner == r_req.free_id) begin
                        n_idx  = r_idx;
                        n_resp.status = ST_OK;
                        n_hit  = rdata;
                        n_hit.used  = 1'b0;
                        n_hit.owner = '0;
                        n_gap  = '0;
                        // look left first if there is a left neighbour
                        n_phase = (r_idx != '0) ? M_LEFT : M_RIGHT;
                        n_ptr   = (r_idx != '0) ? r_idx - CW'(1) : r_idx + CW'(1);
                    end
                end
                // move entries up by one from the top down to make room
                S_SHIFT_RD: raddr = AW'(r_ptr - CW'(1));
                S_SHIFT_WR: begin
                    we    = 1'b1;
                    waddr = r_ptr[AW-1:0];
                    wdata = rdata;
                    n_ptr = r_ptr - CW'(1);
                end
                S_SPLIT_WR: begin
                    we    = 1'b1;
                    waddr = AW'(r_idx + CW'(1));
                    wdata = r_hit;
                    n_cnt = r_cnt + CW'(1);
                end
                S_MERGE_RD: raddr = r_ptr[AW-1:0];
                // absorb free neighbours, then move the entries above down by the gap
                S_MERGE_CHK: begin
                    n_ptr = r_ptr + CW'(1);
                    case (r_phase)
                        M_LEFT: begin
                            if (!rdata.used) begin
                                n_hit.start  = rdata.start;
                                n_hit.length = rdata.length + r_hit.length;
                                n_idx        = r_ptr;
                                n_gap        = CW'(1);
                            end
                            n_ptr   = r_idx + CW'(1);
                            n_phase = M_RIGHT;
                        end
                        M_RIGHT: begin
                            n_phase = M_MOVE;
                            if (!rdata.used) begin
                                n_hit.length = r_hit.length + rdata.length;
                                n_gap        = r_gap + CW'(1);
                            end else begin
                                we    = (r_gap != '0);
                                waddr = AW'(r_ptr - r_gap);
                                wdata = rdata;
                            end
                        end
                        M_MOVE: begin
                            we    = 1'b1;
                            waddr = AW'(r_ptr - r_gap);
                            wdata = rdata;
                        end
                        default: ;
                    endcase
                end
                S_MERGE_WR: begin
                    we    = 1'b1;
                    wdata = r_hit;
                    n_cnt = r_cnt - r_gap;
                end
                S_DONE: n_done = 1'b1;
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after accept");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX && r_cnt != '0)
        else $error("segment count out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_resp.status != ST_OK |-> o_resp.granted_id == '0)
        else $error("id granted on failure");

endmodule
